/* hdl/assert_macros.svh */
// Assertion macros shared by the rational arithmetic unit modules.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
	localparam int OpW   = 16;
	localparam int ProdW = 2 * OpW;
	localparam int NumW  = ProdW + 1;
	localparam int WorkW = 64;
	localparam int CntW  = 7;
	localparam int ResNumW = 33;
	localparam int ResDenW = 32;

	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;
	localparam logic [1:0] MODE_MUL = 2'd2;
	localparam logic [1:0] MODE_DIV = 2'd3;

	typedef enum logic [1:0] {
		DIV_REM  = 2'd0,
		DIV_QNUM = 2'd1,
		DIV_QDEN = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_step;
		logic     euclid_init;
		logic     div_start;
		div_sel_t div_sel;
		logic     swap;
		logic     take_q;
		logic     set_fault;
	} rau_cmd_t;

	typedef struct packed {
		logic add_sub;
		logic den_zero_in;
		logic x_zero;
		logic g_zero;
		logic div_done;
	} rau_sts_t;
endpackage

/* hdl/rau_divider.sv */
// Restoring signed divider, one quotient bit per cycle, truncating.
// Depends on rau_pkg.
module rau_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [rau_pkg::WorkW-1:0] dividend,
	input  logic signed [rau_pkg::WorkW-1:0] divisor,
	output logic                           done,
	output logic signed [rau_pkg::WorkW-1:0] quo,
	output logic signed [rau_pkg::WorkW-1:0] rem
);
	localparam int W = rau_pkg::WorkW;
	logic [W-1:0] r_q, q_q, d_q;
	logic         nq_q, nr_q, busy_q;
	logic [6:0]   cnt_q;
	logic [W:0]   trial;
	logic [W-1:0] r_sh;

	assign r_sh  = {r_q[W-2:0], q_q[W-1]};
	assign trial = {1'b0, r_sh} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q  <= '0;
			q_q  <= dividend[W-1] ? W'(-dividend) : dividend;
			d_q  <= divisor[W-1] ? W'(-divisor) : divisor;
			nq_q <= dividend[W-1] ^ divisor[W-1];
			nr_q <= dividend[W-1];
		end else if (busy_q) begin
			if (!trial[W]) begin
				r_q <= trial[W-1:0];
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= r_sh;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign quo = nq_q ? W'(-q_q) : q_q;
	assign rem = nr_q ? W'(-r_q) : r_q;
endmodule

/* hdl/rau_datapath.sv */
// Datapath: cross products, Euclid registers, quotient results.
// Depends on rau_pkg, rau_divider and assert_macros.svh.
`include "assert_macros.svh"
module rau_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rau_pkg::rau_cmd_t             cmd,
	input  logic [1:0]                    mode,
	input  logic signed [rau_pkg::OpW-1:0] a_num,
	input  logic signed [rau_pkg::OpW-1:0] a_den,
	input  logic signed [rau_pkg::OpW-1:0] b_num,
	input  logic signed [rau_pkg::OpW-1:0] b_den,
	output rau_pkg::rau_sts_t             sts,
	output logic [rau_pkg::ResNumW-1:0]   res_num,
	output logic [rau_pkg::ResDenW-1:0]   res_den,
	output logic                          fault
);
	localparam int W = rau_pkg::WorkW;
	localparam int P = rau_pkg::ProdW;
	logic [1:0] mode_q;
	logic signed [rau_pkg::OpW-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [P-1:0] prod;
	logic signed [rau_pkg::OpW-1:0] m_a, m_b;
	logic [1:0] step_q;
	logic signed [P-1:0] p0_q, p1_q;
	logic signed [W-1:0] num_q, den_q, x_q, y_q, g_q;
	logic signed [W-1:0] dv_n, dv_d, quo, rem;
	logic div_done;

	always_comb begin
		m_a = an_q;
		m_b = bd_q;
		case (step_q)
			2'd0: begin m_a = an_q; m_b = (mode_q == rau_pkg::MODE_MUL) ? bn_q : bd_q; end
			2'd1: begin m_a = bn_q; m_b = ad_q; end
			2'd2: begin m_a = ad_q; m_b = (mode_q == rau_pkg::MODE_DIV) ? bn_q : bd_q; end
			default: begin m_a = an_q; m_b = bd_q; end
		endcase
	end
	assign prod = P'(m_a * m_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
		end else if (cmd.mul_step) begin
			step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			an_q <= a_num; ad_q <= a_den; bn_q <= b_num; bd_q <= b_den;
		end
		if (cmd.mul_step) begin
			case (step_q)
				2'd0: p0_q <= prod;
				2'd1: p1_q <= prod;
				2'd2: begin
					den_q <= W'(prod);
					if (mode_q == rau_pkg::MODE_ADD)
						num_q <= W'(p0_q) + W'(p1_q);
					else if (mode_q == rau_pkg::MODE_SUB)
						num_q <= W'(p0_q) - W'(p1_q);
					else
						num_q <= W'(p0_q);
				end
				default: p0_q <= p0_q;
			endcase
		end
		if (cmd.euclid_init) begin
			x_q <= num_q;
			y_q <= den_q;
		end else if (cmd.swap) begin
			x_q <= (x_q == -W'(1)) ? '0 : rem;
			y_q <= x_q;
		end
		if (cmd.take_q) begin
			if (cmd.div_sel == rau_pkg::DIV_QNUM)
				res_num <= (g_q == -W'(1)) ? rau_pkg::ResNumW'(-num_q)
					: rau_pkg::ResNumW'(quo);
			else
				res_den <= (g_q == -W'(1)) ? rau_pkg::ResDenW'(-den_q)
					: rau_pkg::ResDenW'(quo);
		end
		if (cmd.euclid_init) g_q <= g_q;
		else if (cmd.div_start && cmd.div_sel == rau_pkg::DIV_QNUM) g_q <= y_q;
		if (cmd.set_fault) begin
			res_num <= '0;
			res_den <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fault <= 1'b0;
		else if (cmd.load) fault <= 1'b0;
		else if (cmd.set_fault) fault <= 1'b1;
	end

	always_comb begin
		case (cmd.div_sel)
			rau_pkg::DIV_REM:  begin dv_n = y_q;   dv_d = x_q; end
			rau_pkg::DIV_QNUM: begin dv_n = num_q; dv_d = y_q; end
			rau_pkg::DIV_QDEN: begin dv_n = den_q; dv_d = g_q; end
			default:           begin dv_n = y_q;   dv_d = x_q; end
		endcase
	end

	rau_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.dividend(dv_n), .divisor(dv_d), .done(div_done), .quo(quo), .rem(rem)
	);

	assign sts.add_sub     = (mode_q == rau_pkg::MODE_ADD) || (mode_q == rau_pkg::MODE_SUB);
	assign sts.den_zero_in = (ad_q == '0) || (bd_q == '0);
	assign sts.x_zero      = (x_q == '0);
	assign sts.g_zero      = (y_q == '0);
	assign sts.div_done    = div_done;

	`CHK_NEXT(a_fault_zero, clk, arst_n, cmd.set_fault, (res_num == '0) && (res_den == '0) && fault, "fault result not zero")
	`CHK_IMPL(a_no_swap_zero, clk, arst_n, cmd.swap, !sts.x_zero, "Euclid step with zero divisor")
endmodule

/* hdl/rau_ctrl.sv */
// Controller FSM sequencing products, Euclid loop and final divisions.
// Depends on rau_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rau_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_fire,
	input  rau_pkg::rau_sts_t sts,
	output rau_pkg::rau_cmd_t cmd,
	output logic              in_rdy,
	output logic              out_vld
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_MUL   = 9'b000000010,
		S_CHK   = 9'b000000100,
		S_EUC   = 9'b000001000,
		S_REM   = 9'b000010000,
		S_QN    = 9'b000100000,
		S_QNW   = 9'b001000000,
		S_QDW   = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;
	state_t state_q, state_d;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_MUL) cnt_q <= cnt_q + 2'd1;
			else cnt_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.div_sel = rau_pkg::DIV_REM;
		case (state_q)
			S_IDLE: if (in_fire) begin cmd.load = 1'b1; state_d = S_MUL; end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == 2'd2) state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.add_sub && sts.den_zero_in) begin
					cmd.set_fault = 1'b1; state_d = S_OUT;
				end else begin
					cmd.euclid_init = 1'b1; state_d = S_EUC;
				end
			end
			S_EUC: begin
				if (sts.x_zero) begin
					if (sts.g_zero) begin
						cmd.set_fault = 1'b1; state_d = S_OUT;
					end else begin
						cmd.div_sel = rau_pkg::DIV_QNUM;
						cmd.div_start = 1'b1; state_d = S_QN;
					end
				end else begin
					cmd.div_start = 1'b1; state_d = S_REM;
				end
			end
			S_REM: if (sts.div_done) begin cmd.swap = 1'b1; state_d = S_EUC; end
			S_QN: begin
				cmd.div_sel = rau_pkg::DIV_QNUM;
				if (sts.div_done) begin
					cmd.take_q = 1'b1; state_d = S_QNW;
				end
			end
			S_QNW: begin
				cmd.div_sel = rau_pkg::DIV_QDEN;
				cmd.div_start = 1'b1; state_d = S_QDW;
			end
			S_QDW: begin
				cmd.div_sel = rau_pkg::DIV_QDEN;
				if (sts.div_done) begin cmd.take_q = 1'b1; state_d = S_OUT; end
			end
			S_OUT: if (out_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	assign in_rdy  = (state_q == S_IDLE);
	assign out_vld = (state_q == S_OUT);

	`CHK_IMPL(a_onehot, clk, arst_n, 1'b1, $onehot(state_q), "state not one-hot")
	`CHK_NEXT(a_load_mul, clk, arst_n, cmd.load, state_q == S_MUL, "load not followed by products")
endmodule

/* hdl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: stream ports, controller, datapath.
// Depends on rau_pkg, rau_ctrl, rau_datapath.
//
// Usage: one input transaction on s_axis carries mode and four 16-bit signed
// fraction parts; one output transaction on m_axis returns the reduced
// numerator (33 b), denominator (32 b) and a fault flag in tuser.
// An item runs: three cross products on one shared 16x16 multiplier, a
// check state, then the Euclid loop in which every remainder step runs
// the bit-serial divider, then two quotient divisions. After delivery
// the controller returns to idle, where the next item is accepted.
// The block takes one item at a time: s_axis_tready is high only when idle.
// The result is held in output registers while m_axis_tvalid is high and
// m_axis_tready is low; no new item is taken until it is delivered.
// Reset (arst_n low) returns the controller to idle with no result pending.
// Add/subtract with a zero input denominator, or a zero gcd, give 0/0 with
// fault set.
module rational_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // mode[1:0], a_num, a_den, b_num, b_den, pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // res_num[32:0], res_den[64:33], pad
	output logic        m_axis_tuser   // fault
);
	rau_pkg::rau_cmd_t cmd;
	rau_pkg::rau_sts_t sts;
	logic [rau_pkg::ResNumW-1:0] res_num;
	logic [rau_pkg::ResDenW-1:0] res_den;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid & s_axis_tready),
		.out_fire(m_axis_tvalid & m_axis_tready),
		.sts(sts), .cmd(cmd), .in_rdy(s_axis_tready), .out_vld(m_axis_tvalid)
	);

	rau_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.mode(s_axis_tdata[1:0]),
		.a_num(s_axis_tdata[17:2]), .a_den(s_axis_tdata[33:18]),
		.b_num(s_axis_tdata[49:34]), .b_den(s_axis_tdata[65:50]),
		.sts(sts), .res_num(res_num), .res_den(res_den), .fault(m_axis_tuser)
	);

	assign m_axis_tdata = {7'd0, res_den, res_num};
endmodule
